/* src/psq_pkg.sv */
// Shared codes, defaults and control types for the priority stack queue.
package psq_pkg;

  localparam int PSQ_CAPACITY   = 64;
  localparam int PSQ_VALUE_BITS = 32;
  localparam int PSQ_PRIO_BITS  = 16;

  typedef enum logic [1:0] {
    KIND_PUSH  = 2'd0,
    KIND_POP   = 2'd1,
    KIND_QUERY = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE       = 2'd0,
    ERR_POP_EMPTY  = 2'd1,
    ERR_PUSH_FULL  = 2'd2
  } err_t;

  // Operation broadcast to every cell of the chain.
  typedef struct packed {
    logic push;
    logic pop;
  } psq_op_t;

endpackage

/* src/psq_cell.sv */
// One storage cell of the sorted chain: holds an entry and shifts it to a neighbour.
module psq_cell import psq_pkg::*; #(
  parameter int VALUE_BITS = PSQ_VALUE_BITS,
  parameter int PRIO_BITS  = PSQ_PRIO_BITS
) (
  input  logic                  clk,
  input  psq_op_t               op_i,
  input  logic                  occupied_i,
  input  logic [VALUE_BITS-1:0] new_value_i,
  input  logic [PRIO_BITS-1:0]  new_prio_i,
  input  logic                  left_after_i,
  input  logic [VALUE_BITS-1:0] left_value_i,
  input  logic [PRIO_BITS-1:0]  left_prio_i,
  input  logic [VALUE_BITS-1:0] right_value_i,
  input  logic [PRIO_BITS-1:0]  right_prio_i,
  output logic                  after_o,
  output logic [VALUE_BITS-1:0] value_o,
  output logic [PRIO_BITS-1:0]  prio_o
);

  logic [VALUE_BITS-1:0] value_r, value_nxt;
  logic [PRIO_BITS-1:0]  prio_r, prio_nxt;

  // A new word goes below this cell only if the held priority is strictly higher.
  assign after_o = occupied_i && (prio_r > new_prio_i);

  always_comb begin
    value_nxt = value_r;
    prio_nxt  = prio_r;
    if (op_i.push) begin
      if (!after_o) begin
        if (left_after_i) begin
          value_nxt = new_value_i;
          prio_nxt  = new_prio_i;
        end else begin
          value_nxt = left_value_i;
          prio_nxt  = left_prio_i;
        end
      end
    end else if (op_i.pop) begin
      value_nxt = right_value_i;
      prio_nxt  = right_prio_i;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    prio_r  <= prio_nxt;
  end

  assign value_o = value_r;
  assign prio_o  = prio_r;

endmodule

/* src/priority_stack_queue_top.sv */
// Priority stack queue: a sorted chain of cells with LIFO order among equal priorities.
// The result word is registered and appears in the cycle after its input word is accepted.
// Throughput: one word per cycle unless out_stall holds a valid result; each cell compares its priority
// with the incoming one and picks its next entry from itself, its neighbour or the new word in that cycle.
// Reset clears the entry count and the result valid flag; cell storage is not cleared.
module priority_stack_queue_top import psq_pkg::*; #(
  parameter int CAPACITY   = PSQ_CAPACITY,
  parameter int VALUE_BITS = PSQ_VALUE_BITS,
  parameter int PRIO_BITS  = PSQ_PRIO_BITS,
  localparam int CNT_BITS  = $clog2(CAPACITY + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_kind,
  input  logic [VALUE_BITS-1:0] in_elem_value,
  input  logic [PRIO_BITS-1:0]  in_elem_priority,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [VALUE_BITS-1:0] out_top_value,
  output logic [PRIO_BITS-1:0]  out_top_priority,
  output logic [CNT_BITS-1:0]   out_count,
  output logic                  out_is_empty,
  output logic [1:0]            out_error_code
);

  logic                  in_acc;
  logic                  is_push, is_pop, push_ok, pop_ok;
  psq_op_t               op;
  logic [CNT_BITS-1:0]   count_r, count_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [VALUE_BITS-1:0] top_value_r, top_value_nxt;
  logic [PRIO_BITS-1:0]  top_prio_r, top_prio_nxt;
  logic [CNT_BITS-1:0]   res_count_r;
  logic                  res_empty_r;
  err_t                  err_r, err_nxt;

  logic                  occ      [CAPACITY];
  logic                  after    [CAPACITY];
  logic [VALUE_BITS-1:0] cell_val [CAPACITY];
  logic [PRIO_BITS-1:0]  cell_pri [CAPACITY];

  assign in_stall = out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;

  assign is_push = (in_kind == KIND_PUSH);
  assign is_pop  = (in_kind == KIND_POP);
  assign push_ok = in_acc && is_push && (count_r < CNT_BITS'(CAPACITY));
  assign pop_ok  = in_acc && is_pop && (count_r != '0);

  assign op.push = push_ok;
  assign op.pop  = pop_ok;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                  l_after;
    logic [VALUE_BITS-1:0] l_val, r_val;
    logic [PRIO_BITS-1:0]  l_pri, r_pri;

    assign occ[i] = (count_r > CNT_BITS'(i));

    if (i == 0) begin : g_head
      // The head cell has nothing above it, so an insert there takes the new word.
      assign l_after = 1'b1;
      assign l_val   = '0;
      assign l_pri   = '0;
    end else begin : g_body
      assign l_after = after[i-1];
      assign l_val   = cell_val[i-1];
      assign l_pri   = cell_pri[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign r_val = '0;
      assign r_pri = '0;
    end else begin : g_link
      assign r_val = cell_val[i+1];
      assign r_pri = cell_pri[i+1];
    end

    psq_cell #(
      .VALUE_BITS (VALUE_BITS),
      .PRIO_BITS  (PRIO_BITS)
    ) u_cell (
      .clk           (clk),
      .op_i          (op),
      .occupied_i    (occ[i]),
      .new_value_i   (in_elem_value),
      .new_prio_i    (in_elem_priority),
      .left_after_i  (l_after),
      .left_value_i  (l_val),
      .left_prio_i   (l_pri),
      .right_value_i (r_val),
      .right_prio_i  (r_pri),
      .after_o       (after[i]),
      .value_o       (cell_val[i]),
      .prio_o        (cell_pri[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (push_ok) begin
      count_nxt = count_r + CNT_BITS'(1);
    end else if (pop_ok) begin
      count_nxt = count_r - CNT_BITS'(1);
    end
  end

  // The head entry after the operation, taken from the same choice the head cell makes.
  always_comb begin
    if (push_ok) begin
      top_value_nxt = after[0] ? cell_val[0] : in_elem_value;
      top_prio_nxt  = after[0] ? cell_pri[0] : in_elem_priority;
    end else if (pop_ok) begin
      top_value_nxt = cell_val[1];
      top_prio_nxt  = cell_pri[1];
    end else begin
      top_value_nxt = cell_val[0];
      top_prio_nxt  = cell_pri[0];
    end
    if (count_nxt == '0) begin
      top_value_nxt = '0;
      top_prio_nxt  = '0;
    end
  end

  always_comb begin
    err_nxt = ERR_NONE;
    if (is_push && (count_r >= CNT_BITS'(CAPACITY))) begin
      err_nxt = ERR_PUSH_FULL;
    end else if (is_pop && (count_r == '0)) begin
      err_nxt = ERR_POP_EMPTY;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_acc) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      top_value_r <= top_value_nxt;
      top_prio_r  <= top_prio_nxt;
      res_count_r <= count_nxt;
      res_empty_r <= (count_nxt == '0);
      err_r       <= err_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_top_value    = top_value_r;
  assign out_top_priority = top_prio_r;
  assign out_count        = res_count_r;
  assign out_is_empty     = res_empty_r;
  assign out_error_code   = err_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_BITS'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_empty |-> out_top_value == '0 && out_top_priority == '0
      && out_count == '0)
    else $error("empty result carries a top entry");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && is_pop && count_r != '0 |=> count_r == $past(count_r) - CNT_BITS'(1))
    else $error("pop did not remove exactly one entry");

  a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && is_push && count_r == CNT_BITS'(CAPACITY)
      |=> out_error_code == ERR_PUSH_FULL && count_r == $past(count_r))
    else $error("push on full changed the stack or missed its error");

endmodule

/* verif/priority_stack_queue_top_tb.sv */
// Self-checking testbench for the priority stack queue: random handshakes, in-bench predictor.
module priority_stack_queue_top_tb;
  import psq_pkg::*;

  localparam int CNT_BITS = $clog2(PSQ_CAPACITY + 1);
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD = 300;
  localparam int TARGET_OPS = 650;
  localparam logic [1:0] KIND_SPARE = 2'd3;

  typedef struct packed {
    logic [1:0]                kind;
    logic [PSQ_VALUE_BITS-1:0] value;
    logic [PSQ_PRIO_BITS-1:0]  prio;
    logic [3:0]                gap;
    logic                      drain;
  } stack_op_t;

  typedef struct packed {
    logic [PSQ_VALUE_BITS-1:0] top_value;
    logic [PSQ_PRIO_BITS-1:0]  top_priority;
    logic [CNT_BITS-1:0]       count;
    logic                      is_empty;
    logic [1:0]                error_code;
  } stack_view_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [1:0]                in_kind = KIND_QUERY;
  logic [PSQ_VALUE_BITS-1:0] in_elem_value = '0;
  logic [PSQ_PRIO_BITS-1:0]  in_elem_priority = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [PSQ_VALUE_BITS-1:0] out_top_value;
  logic [PSQ_PRIO_BITS-1:0]  out_top_priority;
  logic [CNT_BITS-1:0]       out_count;
  logic                      out_is_empty;
  logic [1:0]                out_error_code;

  stack_op_t   ops_pending_q[$];
  stack_view_t stack_views_q[$];
  int          failures = 0;
  int          views_seen = 0;
  int          send_gap = 0;
  int          recv_hold = 0;
  int          quiet_cycles = 0;

  // Predictor state: entries sorted with the highest priority in slot zero.
  logic [PSQ_VALUE_BITS-1:0] held_value [PSQ_CAPACITY];
  logic [PSQ_PRIO_BITS-1:0]  held_prio [PSQ_CAPACITY];
  int                        held = 0;

  priority_stack_queue_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_elem_value    (in_elem_value),
    .in_elem_priority (in_elem_priority),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_top_value    (out_top_value),
    .out_top_priority (out_top_priority),
    .out_count        (out_count),
    .out_is_empty     (out_is_empty),
    .out_error_code   (out_error_code)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic stack_view_t apply_to_stack(logic [1:0] op, logic [PSQ_VALUE_BITS-1:0] v,
                                                 logic [PSQ_PRIO_BITS-1:0] p);
    stack_view_t view;
    int slot;
    int i;
    view.error_code = ERR_NONE;
    if (op == KIND_PUSH) begin
      if (held >= PSQ_CAPACITY) begin
        view.error_code = ERR_PUSH_FULL;
      end else begin
        // A new entry goes ahead of all entries of equal priority.
        slot = 0;
        while (slot < held && held_prio[slot] > p) slot++;
        for (i = held; i > slot; i--) begin
          held_value[i] = held_value[i-1];
          held_prio[i] = held_prio[i-1];
        end
        held_value[slot] = v;
        held_prio[slot] = p;
        held++;
      end
    end else if (op == KIND_POP) begin
      if (held == 0) begin
        view.error_code = ERR_POP_EMPTY;
      end else begin
        for (i = 0; i + 1 < held; i++) begin
          held_value[i] = held_value[i+1];
          held_prio[i] = held_prio[i+1];
        end
        held--;
      end
    end
    view.top_value = (held == 0) ? '0 : held_value[0];
    view.top_priority = (held == 0) ? '0 : held_prio[0];
    view.count = held[CNT_BITS-1:0];
    view.is_empty = (held == 0);
    return view;
  endfunction

  task automatic add_op(logic [1:0] k, logic [PSQ_VALUE_BITS-1:0] v,
                        logic [PSQ_PRIO_BITS-1:0] p, int gap, bit drain);
    stack_op_t op;
    op.kind = k;
    op.value = v;
    op.prio = p;
    op.gap = gap[3:0];
    op.drain = drain;
    ops_pending_q.push_back(op);
  endtask

  function automatic logic [PSQ_PRIO_BITS-1:0] draw_prio();
    int pick;
    pick = $urandom_range(0, 3);
    case (pick)
      0: return PSQ_PRIO_BITS'($urandom);
      1: return PSQ_PRIO_BITS'($urandom_range(0, 3));
      2: return ($urandom_range(0, 1) == 1) ? '1 : '0;
      default: return PSQ_PRIO_BITS'($urandom_range(0, 15));
    endcase
  endfunction

  // Driver: the next word is taken from the pending queue once the current one is gone.
  always @(posedge clk) begin
    stack_op_t op;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        stack_views_q.push_back(apply_to_stack(in_kind, in_elem_value, in_elem_priority));
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (ops_pending_q.size() == 0 ||
                     (ops_pending_q[0].drain && stack_views_q.size() != 0)) begin
          in_valid <= 1'b0;
        end else begin
          op = ops_pending_q.pop_front();
          in_valid <= 1'b1;
          in_kind <= op.kind;
          in_elem_value <= op.value;
          in_elem_priority <= op.prio;
          send_gap = op.gap;
        end
      end
    end
  end

  // Monitor: checks each result word and draws the stall that follows it.
  always @(posedge clk) begin
    stack_view_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      recv_hold = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (stack_views_q.size() == 0) begin
          $error("result word arrived with nothing expected");
          failures++;
        end else begin
          want = stack_views_q.pop_front();
          if (out_top_value !== want.top_value) begin
            $error("top_value: expected %0h, got %0h", want.top_value, out_top_value);
            failures++;
          end
          if (out_top_priority !== want.top_priority) begin
            $error("top_priority: expected %0h, got %0h", want.top_priority, out_top_priority);
            failures++;
          end
          if (out_count !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, out_count);
            failures++;
          end
          if (out_is_empty !== want.is_empty) begin
            $error("is_empty: expected %0b, got %0b", want.is_empty, out_is_empty);
            failures++;
          end
          if (out_error_code !== want.error_code) begin
            $error("error_code: expected %0d, got %0d", want.error_code, out_error_code);
            failures++;
          end
        end
        views_seen++;
        if (views_seen == 60 || views_seen == 420)
          recv_hold = LONG_HOLD;
        else if ((views_seen / 80) % 4 == 2)
          recv_hold = 0;
        else
          recv_hold = $urandom_range(0, 15);
      end else if (recv_hold > 0) begin
        recv_hold--;
      end
      out_stall <= (recv_hold > 0);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int total;
    int seg_len;
    int mode;
    int pick;
    int segment;
    int gap;
    bit calm;
    logic [1:0] k;

    // Directed words: empty stack, spare kind, extreme fields, ties, pop to underflow.
    add_op(KIND_QUERY, '0, '0, 0, 1'b0);
    add_op(KIND_POP, '1, '1, 0, 1'b0);
    add_op(KIND_SPARE, '1, '1, 0, 1'b0);
    add_op(KIND_PUSH, 32'hffff_ffff, 16'hffff, 0, 1'b0);
    add_op(KIND_PUSH, 32'h0000_0000, 16'h0000, 0, 1'b0);
    add_op(KIND_PUSH, 32'h0000_0001, 16'hffff, 0, 1'b0);
    add_op(KIND_PUSH, 32'haaaa_5555, 16'h8000, 0, 1'b0);
    add_op(KIND_PUSH, 32'h5555_aaaa, 16'h8000, 0, 1'b0);
    add_op(KIND_PUSH, 32'h1234_5678, 16'h7fff, 0, 1'b0);
    add_op(KIND_SPARE, 32'hdead_beef, 16'h0001, 0, 1'b0);
    add_op(KIND_QUERY, 32'hffff_ffff, 16'hffff, 0, 1'b0);
    for (int i = 0; i < 7; i++)
      add_op(KIND_POP, $urandom, draw_prio(), 0, 1'b0);
    add_op(KIND_QUERY, '0, '0, 0, 1'b0);

    // Fill past capacity, then drain with mostly pops and some queries, with random timing.
    for (int i = 0; i < PSQ_CAPACITY + 5; i++)
      add_op(KIND_PUSH, $urandom, draw_prio(), $urandom_range(0, 15), i == 0);
    for (int i = 0; i < PSQ_CAPACITY + 5; i++) begin
      k = ($urandom_range(0, 7) == 0) ? KIND_QUERY : KIND_POP;
      add_op(k, $urandom, draw_prio(), $urandom_range(0, 15), i == 0);
    end

    // Random segments that lean towards pushes, pops or neither.
    total = ops_pending_q.size();
    segment = 0;
    while (total < TARGET_OPS) begin
      mode = $urandom_range(0, 2);
      seg_len = $urandom_range(20, 60);
      calm = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < seg_len; i++) begin
        pick = $urandom_range(0, 9);
        case (mode)
          0: k = (pick < 8) ? KIND_PUSH : (pick == 8) ? KIND_POP : KIND_QUERY;
          1: k = (pick < 6) ? KIND_POP : (pick < 8) ? KIND_PUSH : KIND_QUERY;
          default: k = (pick < 5) ? KIND_PUSH : (pick < 8) ? KIND_POP : KIND_QUERY;
        endcase
        if (k == KIND_QUERY && $urandom_range(0, 1) == 1) k = KIND_SPARE;
        gap = calm ? 0 : $urandom_range(0, 15);
        add_op(k, $urandom, draw_prio(), gap, i == 0 && segment % 3 == 0);
      end
      total += seg_len;
      segment++;
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    @(negedge clk);
    while (ops_pending_q.size() != 0 || in_valid || stack_views_q.size() != 0)
      @(negedge clk);
    repeat (8) @(negedge clk);
    if (stack_views_q.size() != 0) begin
      $error("%0d expected result words never arrived", stack_views_q.size());
      failures++;
    end
    if (failures == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
